// ===== design/emsp_pkg.sv =====
// ----------------------------------------------------------------------------
// emsp_pkg
// shared types and constants for the motor speed and position loop unit
// ----------------------------------------------------------------------------
package emsp_pkg;

	localparam int TICKS_PER_TURN_DEF = 1024;
	localparam int DUTY_Q4_MAX = 4080;
	localparam int RPM_SCALE = 960000;

	typedef enum logic [1:0] {
		MODE_EDGE = 2'd0,
		MODE_TICK = 2'd1,
		MODE_VEL  = 2'd2,
		MODE_POS  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		REG_IGAIN = 3'd0,
		REG_PGAIN = 3'd1,
		REG_MINDUTY = 3'd2,
		REG_TOL = 3'd3,
		REG_MAXSPD = 3'd4
	} reg_idx_t;

	typedef struct packed {
		mode_t        mode;
		logic [15:0]  elapsed_ms;
		logic signed [15:0] target_rpm;
		logic signed [31:0] target_ticks;
	} item_t;

	typedef struct packed {
		logic [7:0]  duty;
		logic        forward;
		logic [15:0] measured_rpm;
		logic [31:0] position_count;
		logic        move_done;
		logic        accepted;
		logic        in_position_mode;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DIV, ST_DIVEND, ST_LOOP, ST_LOOP2, ST_VDIV, ST_VEND, ST_OUT
	} state_t;

endpackage

// ===== design/emsp_front.sv =====
// ----------------------------------------------------------------------------
// emsp_front
// accepts input words into a two-entry queue for the back end
// ----------------------------------------------------------------------------
module emsp_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  emsp_pkg::item_t in_item,
	output logic            q_valid,
	input  logic            q_ready,
	output emsp_pkg::item_t q_item
);
	emsp_pkg::item_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = mem_q[rp_q];
	assign push = in_valid && in_ready;
	assign pop  = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

// ===== design/emsp_back.sv =====
// ----------------------------------------------------------------------------
// emsp_back
// control sequencer with a shared restoring divider and output register
// ----------------------------------------------------------------------------
module emsp_back #(
	parameter int TICKS_PER_TURN = emsp_pkg::TICKS_PER_TURN_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	output logic              q_ready,
	input  emsp_pkg::item_t   q_item,
	input  logic              cfg_valid,
	input  logic [2:0]        cfg_index,
	input  logic [15:0]       cfg_data,
	output logic              res_valid,
	input  logic              res_ready,
	output emsp_pkg::result_t res
);
	localparam int DW = 52;

	emsp_pkg::state_t st_q, st_d;

	logic [15:0] igain_q, pgain_q, tol_q;
	logic [7:0]  mindut_q;
	logic [10:0] maxspd_q;

	logic [31:0] tick_q, prev_q;
	logic        fwd_q, posc_q, run_q, acc_ok_q;
	logic signed [15:0] vtgt_q, spd_q;
	logic signed [31:0] ptgt_q;
	logic [11:0] duty_q;

	logic [DW-1:0] num_q, den_q, rem_q, quo_q;
	logic [5:0]    cnt_q;
	logic          neg_q;
	logic [32:0]   mag_q;
	logic signed [49:0] prod_q;

	logic [DW:0] trial;
	logic [DW-1:0] rem_sh;
	logic signed [31:0] delta;
	logic [31:0] dmag;
	logic signed [32:0] perr;
	logic [15:0] whole;

	assign rem_sh = {rem_q[DW-2:0], num_q[DW-1]};
	assign trial = {1'b0, rem_sh} - {1'b0, den_q};
	assign delta = tick_q - prev_q;
	assign dmag = delta[31] ? (~delta + 32'd1) : delta;
	assign perr = {ptgt_q[31], ptgt_q} - {tick_q[31], tick_q};
	assign whole = (q_item.target_rpm[15] ? -q_item.target_rpm : q_item.target_rpm) >>> 4;

	always_comb begin
		st_d = st_q;
		case (st_q)
			emsp_pkg::ST_IDLE: if (q_valid) begin
				case (q_item.mode)
					emsp_pkg::MODE_TICK: st_d = (q_item.elapsed_ms == 16'd0) ?
						emsp_pkg::ST_LOOP : emsp_pkg::ST_DIV;
					emsp_pkg::MODE_VEL: st_d = (whole > {5'd0, maxspd_q}
						|| maxspd_q == 11'd0) ? emsp_pkg::ST_OUT : emsp_pkg::ST_VDIV;
					default: st_d = emsp_pkg::ST_OUT;
				endcase
			end
			emsp_pkg::ST_DIV: if (cnt_q == 6'd0) st_d = emsp_pkg::ST_DIVEND;
			emsp_pkg::ST_DIVEND: st_d = emsp_pkg::ST_LOOP;
			emsp_pkg::ST_LOOP: st_d = emsp_pkg::ST_LOOP2;
			emsp_pkg::ST_LOOP2: st_d = emsp_pkg::ST_OUT;
			emsp_pkg::ST_VDIV: if (cnt_q == 6'd0) st_d = emsp_pkg::ST_VEND;
			emsp_pkg::ST_VEND: st_d = emsp_pkg::ST_OUT;
			emsp_pkg::ST_OUT: if (!res_valid || res_ready) st_d = emsp_pkg::ST_IDLE;
			default: st_d = emsp_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		q_ready = (st_q == emsp_pkg::ST_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= emsp_pkg::ST_IDLE;
			igain_q <= 16'd256; pgain_q <= 16'd256; mindut_q <= 8'd45;
			tol_q <= 16'd20; maxspd_q <= 11'd200;
			tick_q <= '0; prev_q <= '0; fwd_q <= 1'b1; posc_q <= 1'b0;
			run_q <= 1'b0; vtgt_q <= '0; spd_q <= '0; ptgt_q <= '0; duty_q <= '0;
			acc_ok_q <= 1'b1; res_valid <= 1'b0; cnt_q <= '0;
		end else begin
			st_q <= st_d;
			if (res_valid && res_ready && st_q != emsp_pkg::ST_OUT) res_valid <= 1'b0;
			if (cfg_valid) begin
				case (cfg_index)
					emsp_pkg::REG_IGAIN: igain_q <= cfg_data;
					emsp_pkg::REG_PGAIN: pgain_q <= cfg_data;
					emsp_pkg::REG_MINDUTY: mindut_q <= cfg_data[7:0];
					emsp_pkg::REG_TOL: tol_q <= cfg_data;
					emsp_pkg::REG_MAXSPD: maxspd_q <= cfg_data[10:0];
					default: ;
				endcase
			end
			case (st_q)
				emsp_pkg::ST_IDLE: if (q_valid) begin
					acc_ok_q <= (q_item.mode != emsp_pkg::MODE_VEL) ||
						(whole <= {5'd0, maxspd_q});
					case (q_item.mode)
						emsp_pkg::MODE_EDGE: tick_q <= fwd_q ? tick_q + 32'd1 : tick_q - 32'd1;
						emsp_pkg::MODE_TICK: if (q_item.elapsed_ms != 16'd0) begin
							num_q <= DW'(dmag) * DW'(emsp_pkg::RPM_SCALE);
							den_q <= DW'(q_item.elapsed_ms) * DW'(TICKS_PER_TURN);
							neg_q <= delta[31];
							prev_q <= tick_q;
							rem_q <= '0; quo_q <= '0; cnt_q <= 6'(DW - 1);
						end
						emsp_pkg::MODE_VEL: begin
							vtgt_q <= q_item.target_rpm;
							posc_q <= 1'b0;
							fwd_q <= !q_item.target_rpm[15];
							if (whole <= {5'd0, maxspd_q}) begin
								if (maxspd_q == 11'd0) duty_q <= '0;
								else begin
									num_q <= DW'(whole) * DW'(255);
									den_q <= DW'(maxspd_q);
									rem_q <= '0; quo_q <= '0; cnt_q <= 6'(DW - 1);
								end
							end
						end
						default: begin
							posc_q <= 1'b1; tick_q <= '0; prev_q <= '0;
							ptgt_q <= q_item.target_ticks; run_q <= 1'b1;
						end
					endcase
				end
				emsp_pkg::ST_DIV, emsp_pkg::ST_VDIV: begin
					num_q <= {num_q[DW-2:0], 1'b0};
					if (!trial[DW]) begin
						rem_q <= trial[DW-1:0];
						quo_q <= {quo_q[DW-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						quo_q <= {quo_q[DW-2:0], 1'b0};
					end
					cnt_q <= cnt_q - 6'd1;
				end
				emsp_pkg::ST_DIVEND: begin
					if (neg_q) spd_q <= (quo_q > DW'(32768)) ? 16'sh8000 : -16'(quo_q);
					else spd_q <= (quo_q > DW'(32767)) ? 16'sh7fff : 16'(quo_q);
				end
				emsp_pkg::ST_VEND: duty_q <= {quo_q[7:0], 4'd0};
				emsp_pkg::ST_LOOP: begin
					if (posc_q) begin
						mag_q <= perr[32] ? 33'(-perr) : 33'(perr);
						fwd_q <= !perr[32];
					end else begin
						prod_q <= $signed({1'b0, igain_q}) *
							($signed({vtgt_q[15], vtgt_q}) - $signed({spd_q[15], spd_q}));
					end
				end
				emsp_pkg::ST_LOOP2: begin
					if (posc_q) begin
						logic [48:0] d;
						d = (49'(pgain_q) * 49'(mag_q)) >> 8;
						if (d < 49'(mindut_q)) d = 49'(mindut_q);
						if (d > 49'd255) d = 49'd255;
						duty_q <= {d[7:0], 4'd0};
						if (mag_q < 33'(tol_q)) run_q <= 1'b0;
					end else begin
						logic signed [51:0] acc;
						logic signed [49:0] ch;
						ch = prod_q >>> 8;
						acc = 52'(duty_q) + (fwd_q ? 52'(ch) : -52'(ch));
						if (acc < 0) duty_q <= '0;
						else if (acc > 52'(emsp_pkg::DUTY_Q4_MAX)) duty_q <= 12'(emsp_pkg::DUTY_Q4_MAX);
						else duty_q <= acc[11:0];
					end
				end
				emsp_pkg::ST_OUT: if (!res_valid || res_ready) begin
					res_valid <= 1'b1;
					res.duty <= duty_q[11:4];
					res.forward <= fwd_q;
					res.measured_rpm <= spd_q;
					res.position_count <= tick_q;
					res.move_done <= !run_q;
					res.accepted <= acc_ok_q;
					res.in_position_mode <= posc_q;
				end
				default: ;
			endcase
		end
	end
endmodule

// ===== design/encoder_motor_speed_position_loop_unit.sv =====
// ----------------------------------------------------------------------------
// encoder_motor_speed_position_loop_unit
// encoder counting, speed measurement, velocity and position loops
// ----------------------------------------------------------------------------
// Encoder edges, position commands and refused velocity commands go straight
// to the output state; control ticks run the loop states, dividing first for
// a nonzero elapsed time, and accepted velocity commands the divide states:
// the speed quotient and the duty scale both run through one bit-serial 52-bit
// divider, one bit per cycle. A two-word queue in front lets input words land
// while the back end works; a stalled result word holds the back end.
module encoder_motor_speed_position_loop_unit #(
	parameter int TICKS_PER_TURN = emsp_pkg::TICKS_PER_TURN_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [63:0]  s_axis_tdata,  // elapsed_ms, target_rpm, target_ticks
	input  logic [1:0]   s_axis_tuser,  // mode
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [63:0]  m_axis_tdata,  // duty, forward, measured_rpm, position_count,
	                                    // move_done, accepted, in_position_mode, pad
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [15:0]  cfg_data
);
	emsp_pkg::item_t in_item, q_item;
	emsp_pkg::result_t res;
	logic q_valid, q_ready;

	assign in_item.mode = emsp_pkg::mode_t'(s_axis_tuser);
	assign in_item.elapsed_ms = s_axis_tdata[15:0];
	assign in_item.target_rpm = s_axis_tdata[31:16];
	assign in_item.target_ticks = s_axis_tdata[63:32];
	assign cfg_ready = 1'b1;

	assign m_axis_tdata = {4'd0, res.in_position_mode, res.accepted, res.move_done,
		res.position_count, res.measured_rpm, res.forward, res.duty};

	emsp_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_item(in_item),
		.q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
	);

	emsp_back #(.TICKS_PER_TURN(TICKS_PER_TURN)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
		.cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res)
	);

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped under stall");
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[63:60] == 4'd0)
		else $error("result padding not zero");
endmodule
